// ===== design/rsfw_pkg.sv =====
// Shared types and constants for the record stream frame window block.
package rsfw_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned REG_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_FRAME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT = 2'd1;

	localparam logic [3:0] HDR_BYTES = 4'd12;
	localparam logic [3:0] LEN_BYTE0 = 4'd8;
	localparam logic [3:0] LEN_BYTE1 = 4'd9;
	localparam logic [3:0] LEN_BYTE2 = 4'd10;
	localparam logic [3:0] LEN_BYTE3 = 4'd11;

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// One classified byte on its way from front to back.
	typedef struct packed {
		logic [7:0] data;
		logic       hdr;
		logic       done;
	} rsfw_item_t;

endpackage

// ===== design/record_stream_frame_window.sv =====
// Top level of the record stream frame window block.
//
// Takes one byte per cycle, while in_stall is low, from a stream of records,
// each a 12-byte header (payload length little-endian in bytes 8 to 11)
// followed by its payload, and returns one result per byte: the byte itself,
// its frame index, header and frame-end flags, the saturating count of
// completed frames, and keep, set when the frame index lies in the window of
// frame_limit frames starting at first_frame (limit 0 keeps all frames from
// first_frame on). Sustained rate is one item per cycle while neither side
// stalls; each item's result passes the front deframer, a four-entry queue
// and the back result register before it is on the outputs. Write
// first_frame and frame_limit only while the block is idle.
module record_stream_frame_window
	import rsfw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           data_out,
	output logic                 keep,
	output logic                 header_byte,
	output logic                 frame_end,
	output logic [31:0]          frame_index,
	output logic [31:0]          frames_complete
);

	logic [REG_W-1:0] first_frame_q;
	logic [REG_W-1:0] frame_limit_q;
	logic             take;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;
	rsfw_item_t       front_item;
	rsfw_item_t       q_item;

	// Hold configuration registers; ignore unknown indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_frame_q <= '0;
			frame_limit_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIRST_FRAME: first_frame_q <= cfg_data;
				REG_FRAME_LIMIT: frame_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Accept an item whenever the queue has room.
	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	rsfw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.item      (front_item)
	);

	rsfw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_item (front_item),
		.pop       (q_pop),
		.pop_item  (q_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	rsfw_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.first_frame     (first_frame_q),
		.frame_limit     (frame_limit_q),
		.q_empty         (q_empty),
		.q_item          (q_item),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.data_out        (data_out),
		.keep            (keep),
		.header_byte     (header_byte),
		.frame_end       (frame_end),
		.frame_index     (frame_index),
		.frames_complete (frames_complete)
	);

endmodule

// ===== design/rsfw_front.sv =====
// Front part: accepts stream bytes and tracks header and payload position.
module rsfw_front
	import rsfw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	output rsfw_item_t item
);

	logic [3:0]  hpos_q;
	logic [31:0] len_q;
	logic [31:0] left_q;

	logic [3:0]  hpos_d;
	logic [31:0] len_d;
	logic [31:0] left_d;
	logic        hdr;
	logic        done;
	logic [31:0] dec;

	// Classify the byte and work out the next deframing state.
	always_comb begin
		hpos_d = hpos_q;
		len_d  = len_q;
		left_d = left_q;
		hdr    = 1'b0;
		done   = 1'b0;
		dec    = (left_q != 32'd0) ? left_q - 32'd1 : 32'd0;
		if (hpos_q < HDR_BYTES) begin
			hdr = 1'b1;
			unique case (hpos_q)
				LEN_BYTE0: len_d = {24'd0, data_byte};
				LEN_BYTE1: len_d = len_q | {16'd0, data_byte, 8'd0};
				LEN_BYTE2: len_d = len_q | {8'd0, data_byte, 16'd0};
				LEN_BYTE3: len_d = len_q | {data_byte, 24'd0};
				default:   len_d = len_q;
			endcase
			hpos_d = hpos_q + 4'd1;
			if (hpos_d == HDR_BYTES) begin
				left_d = len_d;
				done   = (len_d == 32'd0);
			end
		end else begin
			left_d = dec;
			done   = (dec == 32'd0);
		end
		if (done) begin
			hpos_d = 4'd0;
			left_d = 32'd0;
		end
	end

	// Advance the state on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpos_q <= 4'd0;
			len_q  <= 32'd0;
			left_q <= 32'd0;
		end else if (take) begin
			hpos_q <= hpos_d;
			len_q  <= len_d;
			left_q <= left_d;
		end
	end

	assign item.data = data_byte;
	assign item.hdr  = hdr;
	assign item.done = done;

endmodule

// ===== design/rsfw_queue.sv =====
// Short queue of classified items between front and back.
module rsfw_queue
	import rsfw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rsfw_item_t push_item,
	input  logic       pop,
	output rsfw_item_t pop_item,
	output logic       full,
	output logic       empty
);

	rsfw_item_t                 entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]     wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]     rd_ptr_q;
	logic [QUEUE_PTR_W:0]       count_q;

	assign full     = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = entry_q[rd_ptr_q];

	// Store pushed items.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_PTR_W+1)'(1);
			end
		end
	end

endmodule

// ===== design/rsfw_back.sv =====
// Back part: counts frames, applies the window and holds the result register.
module rsfw_back
	import rsfw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [REG_W-1:0] first_frame,
	input  logic [REG_W-1:0] frame_limit,
	input  logic             q_empty,
	input  rsfw_item_t       q_item,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       data_out,
	output logic             keep,
	output logic             header_byte,
	output logic             frame_end,
	output logic [31:0]      frame_index,
	output logic [31:0]      frames_complete
);

	logic [31:0] cnt_q;
	logic        valid_q;
	logic [7:0]  data_s1;
	logic        keep_s1;
	logic        hdr_s1;
	logic        end_s1;
	logic [31:0] idx_s1;
	logic [31:0] done_cnt_s1;

	logic [31:0] cnt_d;
	logic [31:0] offset;
	logic        in_win;

	// Pop when the result register is free or being taken.
	assign q_pop = !q_empty && (!valid_q || !out_stall);

	// Count completed frames, saturating.
	assign cnt_d = (q_item.done && cnt_q != COUNT_MAX) ? cnt_q + 32'd1 : cnt_q;

	// Test the frame index against the window.
	always_comb begin
		offset = cnt_q - {1'b0, first_frame};
		in_win = 1'b0;
		if (cnt_q >= {1'b0, first_frame}) begin
			in_win = (frame_limit == '0) || (offset < {1'b0, frame_limit});
		end
	end

	// Hold the counter and the valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 32'd0;
			valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cnt_q   <= cnt_d;
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Load the result payload on pop.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_s1     <= q_item.data;
			keep_s1     <= in_win;
			hdr_s1      <= q_item.hdr;
			end_s1      <= q_item.done;
			idx_s1      <= cnt_q;
			done_cnt_s1 <= cnt_d;
		end
	end

	assign out_valid       = valid_q;
	assign data_out        = data_s1;
	assign keep            = keep_s1;
	assign header_byte     = hdr_s1;
	assign frame_end       = end_s1;
	assign frame_index     = idx_s1;
	assign frames_complete = done_cnt_s1;

endmodule

// ===== dv/record_stream_frame_window_tb.sv =====
// Self-checking testbench for the record stream frame window block.
module record_stream_frame_window_tb;
	import rsfw_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam logic [REG_W-1:0] REG_TOP = {REG_W{1'b1}};
	localparam int STUCK_LIMIT = 2000;
	localparam int PHASE_BYTES = 250;

	// One predicted result item
	typedef struct packed {
		logic [7:0]  data;
		logic        keep;
		logic        hdr;
		logic        fend;
		logic [31:0] idx;
		logic [31:0] done_cnt;
	} byte_verdict_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FIRST_FRAME;
	logic [REG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           data_byte = 8'd0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [7:0]           data_out;
	logic                 keep;
	logic                 header_byte;
	logic                 frame_end;
	logic [31:0]          frame_index;
	logic [31:0]          frames_complete;

	record_stream_frame_window dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.data_out       (data_out),
		.keep           (keep),
		.header_byte    (header_byte),
		.frame_end      (frame_end),
		.frame_index    (frame_index),
		.frames_complete(frames_complete)
	);

	// Deframer state and window settings as the block should hold them
	logic [3:0]       hdr_pos = '0;
	logic [31:0]      len_acc = '0;
	logic [31:0]      payload_left = '0;
	logic [31:0]      frame_count = '0;
	logic [REG_W-1:0] win_first = '0;
	logic [REG_W-1:0] win_limit = '0;

	logic [7:0]      byte_q[$];
	byte_verdict_t   verdict_q[$];
	int              queued_count = 0;
	int              accepted_count = 0;
	int              fail_count = 0;
	int              tx_idle_pct = 0;
	int              rx_idle_pct = 0;
	int              stuck_cycles = 0;
	logic            in_taken = 1'b0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic in_window(input logic [31:0] f);
		if (f < {1'b0, win_first})
			return 1'b0;
		if (win_limit == '0)
			return 1'b1;
		return (f - {1'b0, win_first}) < {1'b0, win_limit};
	endfunction

	// Advance the deframer by one byte and return what the block should report
	function automatic byte_verdict_t classify_byte(input logic [7:0] b);
		byte_verdict_t v;
		logic hdr;
		logic done;
		logic [31:0] idx;
		idx = frame_count;
		hdr = 1'b0;
		done = 1'b0;
		if (hdr_pos < HDR_BYTES) begin
			hdr = 1'b1;
			case (hdr_pos)
				LEN_BYTE0: len_acc = {24'd0, b};
				LEN_BYTE1: len_acc[15:8] = b;
				LEN_BYTE2: len_acc[23:16] = b;
				LEN_BYTE3: len_acc[31:24] = b;
				default: ;
			endcase
			hdr_pos = hdr_pos + 4'd1;
			if (hdr_pos == HDR_BYTES) begin
				payload_left = len_acc;
				if (payload_left == '0)
					done = 1'b1;
			end
		end else begin
			if (payload_left != '0)
				payload_left = payload_left - 32'd1;
			if (payload_left == '0)
				done = 1'b1;
		end
		if (done) begin
			hdr_pos = '0;
			payload_left = '0;
			if (frame_count != COUNT_MAX)
				frame_count = frame_count + 32'd1;
		end
		v.data = b;
		v.keep = in_window(idx);
		v.hdr = hdr;
		v.fend = done;
		v.idx = idx;
		v.done_cnt = frame_count;
		return v;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Feed pending bytes, holding a stalled item until it is taken
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_valid <= 1'b1;
				data_byte <= byte_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// Check each result item, then predict for each accepted input item
	always @(posedge clk) begin : track
		byte_verdict_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$error("unexpected item: data_out 0x%0h", data_out);
					fail_count++;
				end else begin
					want = verdict_q.pop_front();
					check_field("data_out", want.data, data_out);
					check_field("keep", want.keep, keep);
					check_field("header_byte", want.hdr, header_byte);
					check_field("frame_end", want.fend, frame_end);
					check_field("frame_index", want.idx, frame_index);
					check_field("frames_complete", want.done_cnt, frames_complete);
				end
			end
			if (in_valid && !in_stall) begin
				verdict_q.push_back(classify_byte(data_byte));
				accepted_count++;
			end
			in_taken <= in_valid && !in_stall;
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("record_stream_frame_window: mismatch");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		byte_q.push_back(b);
		queued_count++;
	endtask

	// Queue one record: random header, given length, pay_bytes random payload bytes
	task automatic push_frame(input logic [31:0] len, input int pay_bytes);
		for (int i = 0; i < 8; i++)
			push_byte(8'($urandom_range(255)));
		for (int i = 0; i < 4; i++)
			push_byte(len[8*i +: 8]);
		for (int i = 0; i < pay_bytes; i++)
			push_byte(8'($urandom_range(255)));
	endtask

	// Wait until every queued item is taken and every result has come back
	task automatic drain();
		while (accepted_count != queued_count || verdict_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FIRST_FRAME)
			win_first = val;
		else if (idx == REG_FRAME_LIMIT)
			win_limit = val;
	endtask

	initial begin : stimulus
		int start;
		int roll;
		logic [31:0] len;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			repeat (4) @(negedge clk);
			case (ph)
				0: begin
					write_reg(REG_FIRST_FRAME, '0);
					write_reg(REG_FRAME_LIMIT, '0);
				end
				1: begin
					write_reg(REG_FIRST_FRAME, REG_W'(frame_count + 32'd1));
					write_reg(REG_FRAME_LIMIT, REG_W'(2));
				end
				2: begin
					write_reg(REG_FIRST_FRAME, REG_TOP);
					write_reg(REG_FRAME_LIMIT, REG_TOP);
				end
				3: begin
					write_reg(REG_FIRST_FRAME, '0);
					write_reg(REG_FRAME_LIMIT, REG_W'(frame_count + 32'd2));
				end
				4: begin
					write_reg(REG_FIRST_FRAME, REG_W'(frame_count));
					write_reg(REG_FRAME_LIMIT, REG_TOP);
					// unused indexes must leave the window alone
					write_reg(REG_SPARE_2, REG_W'($urandom));
					write_reg(REG_SPARE_3, REG_TOP);
				end
				default: begin
					write_reg(REG_FIRST_FRAME, REG_W'(frame_count + 32'd3));
					write_reg(REG_FRAME_LIMIT, '0);
				end
			endcase
			@(posedge clk);
			if (ph < 2) begin
				tx_idle_pct = 8;
				rx_idle_pct = 71;
			end else if (ph < 4) begin
				tx_idle_pct = 71;
				rx_idle_pct = 8;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (ph == 0) begin
				// zero-length frame: ends on its last header byte
				for (int i = 0; i < 8; i++)
					push_byte(8'hFF);
				for (int i = 0; i < 4; i++)
					push_byte(8'h00);
				// one-byte payload
				for (int i = 0; i < 8; i++)
					push_byte(8'h00);
				push_byte(8'h01);
				for (int i = 0; i < 3; i++)
					push_byte(8'h00);
				push_byte(8'hFF);
			end
			start = queued_count;
			while (queued_count - start < PHASE_BYTES) begin
				roll = $urandom_range(99);
				if (roll < 10)
					len = '0;
				else if (roll < 80)
					len = $urandom_range(24, 1);
				else if (roll < 97)
					len = $urandom_range(120, 25);
				else
					len = $urandom_range(600, 256);
				push_frame(len, int'(len));
			end
			if (ph == 5) begin
				// trailing partial frame with every length bit set
				push_frame(32'hFFFF_FFFF, 20);
			end
		end
		drain();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("record_stream_frame_window: match");
		else
			$display("record_stream_frame_window: mismatch");
		$finish;
	end

endmodule
